>>> src/assert_macros.svh
// assertion macros used by the checker file
// depends on nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a true antecedent requires the consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// a true antecedent requires the consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

>>> src/cdad_pkg.sv
// shared types, constants and functions of the date adder
// depends on nothing
package cdad_pkg;

    localparam int unsigned YEAR_W     = 15;
    localparam int unsigned YP_W       = 29;
    localparam int unsigned YMOD_SHIFT = 19;
    localparam int unsigned YQ_W       = 10;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 15'd9999;
    localparam logic [14:0]       YMOD_K   = 15'd20972;
    localparam logic [4:0]        MOD25    = 5'd25;
    localparam logic [2:0]        MOD7     = 3'd7;
    localparam logic [3:0]        MON_JAN  = 4'd1;
    localparam logic [3:0]        MON_FEB  = 4'd2;
    localparam logic [3:0]        MON_APR  = 4'd4;
    localparam logic [3:0]        MON_JUN  = 4'd6;
    localparam logic [3:0]        MON_SEP  = 4'd9;
    localparam logic [3:0]        MON_NOV  = 4'd11;
    localparam logic [3:0]        MON_DEC  = 4'd12;

    typedef struct packed {
        logic load;
        logic rem;
        logic step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic fits;
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_REM  = 3'b010,
        ST_LOOP = 3'b100
    } state_t;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        begin
            len = 5'd31;
            if (month == MON_FEB)
            begin
                len = leap ? 5'd29 : 5'd28;
            end
            else if (month == MON_APR || month == MON_JUN || month == MON_SEP ||
                     month == MON_NOV)
            begin
                len = 5'd30;
            end
            return len;
        end
    endfunction

endpackage

>>> src/calendar_date_add_days_top.sv
// Gregorian date adder: adds a day count to a date and its weekday.
// Input channel in_valid/in_stall carries day_in, month_in, year_in, weekday_in
// and increment; output channel out_valid/out_stall carries day_out, month_out,
// year_out, weekday_out and year_overflow. An item moves when valid is high and
// stall is low. One result per item.
// After an item is taken, a setup state forms the weekday and year remainders,
// then the month loop steps one month at a time until the day count fits the
// current month, and then hands the result to the output register.
// in_stall is high while an item is in work. The result sits in an output
// register, so the next item is taken while the result waits; a stalled result
// holds and the loop waits at its end until the register frees.
// Reset clears the controller and the output valid; no item is in flight.
// depends on cdad_pkg, cdad_ctrl, cdad_datapath
module calendar_date_add_days_top
    import cdad_pkg::*;
#(
    parameter int unsigned INCREMENT_BITS = 10
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [4:0]                day_in,
    input  logic [3:0]                month_in,
    input  logic [13:0]               year_in,
    input  logic [2:0]                weekday_in,
    input  logic [INCREMENT_BITS-1:0] increment,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [4:0]                day_out,
    output logic [3:0]                month_out,
    output logic [13:0]               year_out,
    output logic [2:0]                weekday_out,
    output logic                      year_overflow
);

    cmd_t    cmd;
    status_t status;

    cdad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    cdad_datapath #(
        .INCREMENT_BITS (INCREMENT_BITS)
    ) u_datapath (
        .clk           (clk),
        .cmd           (cmd),
        .status        (status),
        .day_in        (day_in),
        .month_in      (month_in),
        .year_in       (year_in),
        .weekday_in    (weekday_in),
        .increment     (increment),
        .day_out       (day_out),
        .month_out     (month_out),
        .year_out      (year_out),
        .weekday_out   (weekday_out),
        .year_overflow (year_overflow)
    );

endmodule

>>> src/cdad_ctrl.sv
// controller of the date adder: sequencing and output valid
// depends on cdad_pkg
module cdad_ctrl
    import cdad_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_REM;
                end
            end
            ST_REM:
            begin
                cmd.rem    = 1'b1;
                state_next = ST_LOOP;
            end
            ST_LOOP:
            begin
                if (!status.fits)
                begin
                    cmd.step = 1'b1;
                end
                else if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> src/cdad_datapath.sv
// datapath of the date adder: setup remainders, month loop, output register
// depends on cdad_pkg
module cdad_datapath
    import cdad_pkg::*;
#(
    parameter int unsigned INCREMENT_BITS = 10
)
(
    input  logic                      clk,
    input  cmd_t                      cmd,
    output status_t                   status,
    input  logic [4:0]                day_in,
    input  logic [3:0]                month_in,
    input  logic [13:0]               year_in,
    input  logic [2:0]                weekday_in,
    input  logic [INCREMENT_BITS-1:0] increment,
    output logic [4:0]                day_out,
    output logic [3:0]                month_out,
    output logic [13:0]               year_out,
    output logic [2:0]                weekday_out,
    output logic                      year_overflow
);

    localparam int unsigned DAY_W    = ((INCREMENT_BITS > 5) ? INCREMENT_BITS : 5) + 1;
    localparam int unsigned W7_SHIFT = DAY_W + 3;
    localparam int unsigned PW7      = 2 * DAY_W + 1;
    localparam longint unsigned W7_K = ((64'd1 << W7_SHIFT) + 64'd6) / 64'd7;

    logic [DAY_W-1:0]  day_reg;
    logic [DAY_W-1:0]  day_next;
    logic [3:0]        month_reg;
    logic [3:0]        month_next;
    logic [YEAR_W-1:0] year_reg;
    logic [YEAR_W-1:0] year_next;
    logic [4:0]        ymod_reg;
    logic [4:0]        ymod_next;
    logic [DAY_W-1:0]  wsum_reg;
    logic [PW7-1:0]    wprod_reg;
    logic [YP_W-1:0]   yprod_reg;
    logic [2:0]        wd_reg;
    logic [2:0]        wd_next;

    logic [4:0]        dout_reg;
    logic [3:0]        mout_reg;
    logic [13:0]       yout_reg;
    logic [2:0]        wout_reg;
    logic              ovf_reg;

    logic [DAY_W-1:0]  wsum_in;
    logic [3:0]        month_fix;
    logic [DAY_W-1:0]  wq;
    logic [DAY_W-1:0]  wr;
    logic [YQ_W-1:0]   yq;
    logic [13:0]       yr;
    logic              leap;
    logic [4:0]        len;
    logic              over;

    assign wsum_in   = DAY_W'(weekday_in) + DAY_W'(increment);
    assign month_fix = (month_in == 4'd0 || month_in > MON_DEC) ? MON_JAN : month_in;

    // quotients by reciprocal, one correction step each
    always_comb
    begin
        wq = DAY_W'(wprod_reg >> W7_SHIFT);
        wr = wsum_reg - (wq * DAY_W'(MOD7));
        if (wr >= DAY_W'(MOD7))
        begin
            wr = wr - DAY_W'(MOD7);
        end
        yq = YQ_W'(yprod_reg >> YMOD_SHIFT);
        yr = year_reg[13:0] - (14'(yq) * 14'(MOD25));
        if (yr >= 14'(MOD25))
        begin
            yr = yr - 14'(MOD25);
        end
    end

    assign leap        = (year_reg[1:0] == 2'd0) && (ymod_reg != 5'd0 || year_reg[3:0] == 4'd0);
    assign len         = month_len(month_reg, leap);
    assign status.fits = (day_reg <= DAY_W'(len));
    assign over        = (year_reg > YEAR_MAX);

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        ymod_next  = ymod_reg;
        wd_next    = wd_reg;
        if (cmd.load)
        begin
            day_next   = DAY_W'(day_in) + DAY_W'(increment);
            month_next = month_fix;
            year_next  = YEAR_W'(year_in);
        end
        if (cmd.rem)
        begin
            ymod_next = yr[4:0];
            wd_next   = (wr[2:0] == 3'd0) ? MOD7 : wr[2:0];
        end
        if (cmd.step)
        begin
            day_next = day_reg - DAY_W'(len);
            if (month_reg == MON_DEC)
            begin
                month_next = MON_JAN;
                year_next  = year_reg + YEAR_W'(1);
                ymod_next  = (ymod_reg == MOD25 - 5'd1) ? 5'd0 : ymod_reg + 5'd1;
            end
            else
            begin
                month_next = month_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        ymod_reg  <= ymod_next;
        wd_reg    <= wd_next;
        if (cmd.load)
        begin
            wsum_reg  <= wsum_in;
            wprod_reg <= PW7'(wsum_in) * PW7'(W7_K);
            yprod_reg <= YP_W'(year_in) * YP_W'(YMOD_K);
        end
        if (cmd.emit)
        begin
            dout_reg <= day_reg[4:0];
            mout_reg <= month_reg;
            yout_reg <= over ? YEAR_MAX[13:0] : year_reg[13:0];
            wout_reg <= wd_reg;
            ovf_reg  <= over;
        end
    end

    assign day_out       = dout_reg;
    assign month_out     = mout_reg;
    assign year_out      = yout_reg;
    assign weekday_out   = wout_reg;
    assign year_overflow = ovf_reg;

endmodule

>>> src/cdad_checker.sv
// port-level checks of the date adder and their bind to the top level
// depends on assert_macros.svh and calendar_date_add_days_top
`include "assert_macros.svh"

module cdad_checker #(
    parameter int unsigned INCREMENT_BITS = 10
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic [4:0]                day_in,
    input logic [3:0]                month_in,
    input logic [13:0]               year_in,
    input logic [2:0]                weekday_in,
    input logic [INCREMENT_BITS-1:0] increment,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [4:0]                day_out,
    input logic [3:0]                month_out,
    input logic [13:0]               year_out,
    input logic [2:0]                weekday_out,
    input logic                      year_overflow
);

    logic in_take;

    assign in_take = in_valid && !in_stall;

    // one item in work at a time
    `ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_take, in_stall)
    // a stalled item holds
    `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall,
        in_valid && $stable(day_in) && $stable(month_in) && $stable(year_in) &&
        $stable(weekday_in) && $stable(increment))
    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(day_out) && $stable(month_out) && $stable(year_out) &&
        $stable(weekday_out) && $stable(year_overflow))
    // overflow pins the year
    `ASSERT_SAME(a_ovf_year, clk, rst_n, out_valid && year_overflow, year_out == 14'd9999)
    // month and weekday stay in range
    `ASSERT_SAME(a_out_range, clk, rst_n, out_valid,
        weekday_out != 3'd0 && month_out != 4'd0 && month_out <= 4'd12)

endmodule

bind calendar_date_add_days_top cdad_checker #(
    .INCREMENT_BITS (INCREMENT_BITS)
) u_cdad_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .day_in        (day_in),
    .month_in      (month_in),
    .year_in       (year_in),
    .weekday_in    (weekday_in),
    .increment     (increment),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .day_out       (day_out),
    .month_out     (month_out),
    .year_out      (year_out),
    .weekday_out   (weekday_out),
    .year_overflow (year_overflow)
);
